### rtl/w3f_pkg.sv
// shared types, constants and codes of the 3x3 window image filter
`default_nettype none
package w3f_pkg;

    localparam int MAX_LINE_WIDTH = 1024;
    localparam int MAX_CHANNELS   = 3;
    localparam int COL_W          = $clog2(MAX_LINE_WIDTH);
    localparam int LW_W           = 11;
    localparam int SQRT_STEPS     = 11;
    localparam int STEP_W         = $clog2(SQRT_STEPS);
    localparam logic [12:0] AVG_RECIP = 13'd7282;

    localparam logic [1:0] REG_MODE  = 2'd0;
    localparam logic [1:0] REG_WIDTH = 2'd1;
    localparam logic [1:0] REG_CHANS = 2'd2;

    typedef enum logic [2:0] {
        MODE_AVERAGE   = 3'd0,
        MODE_GAUSSIAN  = 3'd1,
        MODE_LAPLACIAN = 3'd2,
        MODE_SHARPEN   = 3'd3,
        MODE_SOBEL     = 3'd4,
        MODE_MEDIAN    = 3'd5
    } mode_e;

    typedef enum logic {F_IDLE, F_PUSH} fstate_t;
    typedef enum logic [1:0] {B_IDLE, B_CALC, B_SQRT, B_DONE} bstate_t;

    typedef struct packed {
        logic       frame_start;
        logic [7:0] pixel_c0;
        logic [7:0] pixel_c1;
        logic [7:0] pixel_c2;
    } pixel_t;

    typedef struct packed {
        logic signed [11:0] filtered_c0;
        logic signed [11:0] filtered_c1;
        logic signed [11:0] filtered_c2;
        logic               row_end;
    } result_t;

    typedef struct packed {
        logic [2:0]      mode;
        logic [LW_W-1:0] line_width;
        logic [1:0]      channel_count;
    } cfg_t;

    typedef struct packed {
        logic [MAX_CHANNELS-1:0][8:0][7:0] win;
        logic                              row_end;
    } win_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage
`default_nettype wire

### rtl/w3f_queue.sv
// two-entry queue of windows between front and back
`default_nettype none
module w3f_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wr,
    input  wire w3f_pkg::win_t wr_data,
    input  wire logic          rd,
    output w3f_pkg::win_t      rd_data,
    output w3f_pkg::q_stat_t   stat
);
    import w3f_pkg::*;

    win_t       mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign rd_data    = mem_reg[rp_reg];
    assign stat.full  = cnt_reg == 2'd2;
    assign stat.empty = cnt_reg == 2'd0;

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem_reg[wp_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr) wp_reg <= ~wp_reg;
            if (rd) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, wr} - {1'b0, rd};
        end
    end
endmodule
`default_nettype wire

### rtl/w3f_front.sv
// line buffers, window columns and raster counters
`default_nettype none
module w3f_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire w3f_pkg::cfg_t    cfg,
    input  wire logic             push,
    input  wire w3f_pkg::pixel_t  pixel,
    output logic                  full,
    input  wire w3f_pkg::q_stat_t q_stat,
    output logic                  q_wr,
    output w3f_pkg::win_t         q_data
);
    import w3f_pkg::*;

    logic [47:0]      line_mem [MAX_LINE_WIDTH];
    logic [47:0]      rd_reg;
    logic [23:0]      cur_reg;
    logic [23:0]      wc_reg [6];
    logic [COL_W-1:0] cc_reg, cc_next, col_acc;
    logic [1:0]       rc_reg, rc_next, rc_acc;
    fstate_t          state_reg, state_next;
    logic [LW_W-1:0]  lw;
    logic [LW_W-1:0]  col_inc;
    logic             accept, emit, last, done;
    logic [23:0]      col2 [3];

    always_comb
    begin
        if (cfg.line_width < LW_W'(3))
            lw = LW_W'(3);
        else if (cfg.line_width > LW_W'(MAX_LINE_WIDTH))
            lw = LW_W'(MAX_LINE_WIDTH);
        else
            lw = cfg.line_width;
    end

    assign full   = state_reg != F_IDLE;
    assign accept = push && !full;

    // position of the incoming pixel
    always_comb
    begin
        col_acc = cc_reg;
        rc_acc  = rc_reg;
        if (pixel.frame_start)
        begin
            col_acc = '0;
            rc_acc  = '0;
        end
        if ({1'b0, col_acc} >= lw)
        begin
            col_acc = '0;
            if (rc_acc < 2'd2) rc_acc = rc_acc + 2'd1;
        end
    end

    assign col_inc = {1'b0, cc_reg} + LW_W'(1);
    assign last    = col_inc >= lw;
    assign emit    = (rc_reg == 2'd2) && (cc_reg >= COL_W'(2));

    assign col2[0] = rd_reg[23:0];
    assign col2[1] = rd_reg[47:24];
    assign col2[2] = cur_reg;

    always_comb
    begin
        for (int k = 0; k < MAX_CHANNELS; k++)
        begin
            for (int r = 0; r < 3; r++)
            begin
                q_data.win[k][r*3]   = wc_reg[r][k*8 +: 8];
                q_data.win[k][r*3+1] = wc_reg[3+r][k*8 +: 8];
                q_data.win[k][r*3+2] = col2[r][k*8 +: 8];
            end
        end
        q_data.row_end = last;
    end

    always_comb
    begin
        state_next = state_reg;
        cc_next    = cc_reg;
        rc_next    = rc_reg;
        done       = 1'b0;
        q_wr       = 1'b0;
        unique case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    cc_next    = col_acc;
                    rc_next    = rc_acc;
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (!emit || !q_stat.full)
                begin
                    done       = 1'b1;
                    q_wr       = emit;
                    state_next = F_IDLE;
                    if (last)
                    begin
                        cc_next = '0;
                        if (rc_reg < 2'd2) rc_next = rc_reg + 2'd1;
                    end
                    else
                    begin
                        cc_next = col_inc[COL_W-1:0];
                    end
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_reg  <= line_mem[col_acc];
            cur_reg <= {pixel.pixel_c2, pixel.pixel_c1, pixel.pixel_c0};
        end
        if (done)
        begin
            line_mem[cc_reg] <= {cur_reg, rd_reg[47:24]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            cc_reg    <= '0;
            rc_reg    <= '0;
            for (int i = 0; i < 6; i++) wc_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cc_reg    <= cc_next;
            rc_reg    <= rc_next;
            if (done)
            begin
                for (int r = 0; r < 3; r++)
                begin
                    wc_reg[r]   <= wc_reg[3+r];
                    wc_reg[3+r] <= col2[r];
                end
            end
        end
    end
endmodule
`default_nettype wire

### rtl/w3f_back.sv
// filter arithmetic, serial square root and result register
`default_nettype none
module w3f_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire w3f_pkg::cfg_t    cfg,
    input  wire w3f_pkg::q_stat_t q_stat,
    input  wire w3f_pkg::win_t    q_data,
    output logic                  q_rd,
    input  wire logic             pop,
    output logic                  empty,
    output w3f_pkg::result_t      result
);
    import w3f_pkg::*;

    bstate_t                state_reg, state_next;
    win_t                   win_reg;
    logic signed [11:0]     res_reg  [MAX_CHANNELS];
    logic [21:0]            rad_reg  [MAX_CHANNELS];
    logic [11:0]            rem_reg  [MAX_CHANNELS];
    logic [10:0]            root_reg [MAX_CHANNELS];
    logic [STEP_W-1:0]      step_reg;
    logic                   out_valid_reg;
    result_t                out_reg;
    logic signed [11:0]     res_c   [MAX_CHANNELS];
    logic [21:0]            sq_c    [MAX_CHANNELS];
    logic signed [11:0]     fin     [MAX_CHANNELS];
    logic [1:0]             chans;
    logic                   load_out;

    assign empty  = !out_valid_reg;
    assign result = out_reg;
    assign chans  = (cfg.channel_count == 2'd0) ? 2'd1 : cfg.channel_count;

    // per component arithmetic on the registered window
    always_comb
    begin
        logic [7:0]         w [9];
        logic [11:0]        sum, gsum;
        logic [24:0]        prod;
        logic signed [12:0] lap, shp;
        logic signed [11:0] gx, gy;
        logic [21:0]        gx2, gy2;
        logic [3:0]         rank;
        logic [7:0]         med;
        for (int k = 0; k < MAX_CHANNELS; k++)
        begin
            for (int i = 0; i < 9; i++) w[i] = win_reg.win[k][i];
            sum = '0;
            for (int i = 0; i < 9; i++) sum = sum + 12'(w[i]);
            gsum = 12'(w[0]) + 12'(w[2]) + 12'(w[6]) + 12'(w[8])
                 + {3'b0, w[1], 1'b0} + {3'b0, w[3], 1'b0}
                 + {3'b0, w[5], 1'b0} + {3'b0, w[7], 1'b0} + {2'b0, w[4], 2'b0};
            prod = 25'(sum) * 25'(AVG_RECIP);
            lap  = 13'(w[1]) + 13'(w[3]) + 13'(w[5]) + 13'(w[7])
                 - {3'b0, w[4], 2'b0};
            shp  = 13'(12'(w[4]) * 12'd10) - 13'(sum);
            gx   = 12'(w[0]) - 12'(w[2]) + {3'b0, w[3], 1'b0} - {3'b0, w[5], 1'b0}
                 + 12'(w[6]) - 12'(w[8]);
            gy   = 12'(w[0]) + {3'b0, w[1], 1'b0} + 12'(w[2])
                 - 12'(w[6]) - {3'b0, w[7], 1'b0} - 12'(w[8]);
            gx2  = 22'(gx * gx);
            gy2  = 22'(gy * gy);
            sq_c[k] = gx2 + gy2;
            // median: the sample whose stable rank is four
            med = '0;
            for (int i = 0; i < 9; i++)
            begin
                rank = '0;
                for (int j = 0; j < 9; j++)
                begin
                    if ((w[j] < w[i]) || ((w[j] == w[i]) && (j < i)))
                        rank = rank + 4'd1;
                end
                if (rank == 4'd4) med = w[i];
            end
            unique case (cfg.mode)
                MODE_AVERAGE:   res_c[k] = {3'b0, prod[24:16]};
                MODE_GAUSSIAN:  res_c[k] = {4'b0, gsum[11:4]};
                MODE_LAPLACIAN: res_c[k] = lap[11:0];
                MODE_SHARPEN:
                begin
                    if (shp < 13'sd0)        res_c[k] = '0;
                    else if (shp > 13'sd255) res_c[k] = 12'sd255;
                    else                     res_c[k] = shp[11:0];
                end
                MODE_MEDIAN:    res_c[k] = {4'b0, med};
                default:        res_c[k] = '0;
            endcase
        end
    end

    always_comb
    begin
        for (int k = 0; k < MAX_CHANNELS; k++)
        begin
            if (k >= int'(chans))
                fin[k] = '0;
            else if (cfg.mode == MODE_SOBEL)
                fin[k] = {1'b0, root_reg[k]};
            else
                fin[k] = res_reg[k];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        q_rd       = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    q_rd       = 1'b1;
                    state_next = B_CALC;
                end
            end
            B_CALC: state_next = (cfg.mode == MODE_SOBEL) ? B_SQRT : B_DONE;
            B_SQRT:
            begin
                if (step_reg == STEP_W'(SQRT_STEPS - 1)) state_next = B_DONE;
            end
            B_DONE:
            begin
                if (!out_valid_reg || pop)
                begin
                    load_out   = 1'b1;
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        logic [12:0] rem_n, trial;
        if (q_rd) win_reg <= q_data;
        for (int k = 0; k < MAX_CHANNELS; k++)
        begin
            if (state_reg == B_CALC)
            begin
                res_reg[k]  <= res_c[k];
                rad_reg[k]  <= sq_c[k];
                rem_reg[k]  <= '0;
                root_reg[k] <= '0;
            end
            else if (state_reg == B_SQRT)
            begin
                rem_n = {rem_reg[k][10:0], rad_reg[k][21:20]};
                trial = {root_reg[k], 2'b01};
                rad_reg[k] <= {rad_reg[k][19:0], 2'b00};
                if (rem_n >= trial)
                begin
                    rem_reg[k]  <= 12'(rem_n - trial);
                    root_reg[k] <= {root_reg[k][9:0], 1'b1};
                end
                else
                begin
                    rem_reg[k]  <= rem_n[11:0];
                    root_reg[k] <= {root_reg[k][9:0], 1'b0};
                end
            end
        end
        if (load_out)
        begin
            out_reg.filtered_c0 <= fin[0];
            out_reg.filtered_c1 <= fin[1];
            out_reg.filtered_c2 <= fin[2];
            out_reg.row_end     <= win_reg.row_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= (state_reg == B_SQRT) ? step_reg + STEP_W'(1) : '0;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (pop)
                out_valid_reg <= 1'b0;
        end
    end
endmodule
`default_nettype wire

### rtl/window_3x3_image_filter_unit.sv
// top level of the 3x3 window image filter with its register port
// A raster stream of pixels (up to three 8-bit components) enters through push/full and
// filtered results for the (width-2) by (height-2) interior leave through empty/pop.
// The front reads the shared line buffer memory as it takes a pixel, then writes it back and
// hands the 3x3 window to a two-beat queue, waiting while the queue is full; it takes no new
// pixel before that. The back reads the queue, does the arithmetic and loads the result
// register once any result still held is popped; in sobel mode the serial square root settles
// one root bit per cycle between the two. Front and back overlap, so the sustained rate is set
// by the slower of the two. Line buffers come up undefined and are not cleared. The user must
// write registers only while the block is idle; the block itself does not enforce this.
`default_nettype none
module window_3x3_image_filter_unit (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             psel,
    input  wire logic             penable,
    input  wire logic             pwrite,
    input  wire logic [3:0]       paddr,
    input  wire logic [31:0]      pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    input  wire logic             push,
    input  wire w3f_pkg::pixel_t  pixel,
    output logic                  full,
    output logic                  empty,
    input  wire logic             pop,
    output w3f_pkg::result_t      result
);
    import w3f_pkg::*;

    cfg_t    cfg_reg;
    q_stat_t q_stat;
    win_t    q_wr_data, q_rd_data;
    logic    q_wr, q_rd;
    logic    cfg_wr;

    // register port, always ready
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode          <= MODE_AVERAGE;
            cfg_reg.line_width    <= LW_W'(640);
            cfg_reg.channel_count <= 2'd1;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_MODE:  cfg_reg.mode          <= pwdata[2:0];
                REG_WIDTH: cfg_reg.line_width    <= pwdata[LW_W-1:0];
                REG_CHANS: cfg_reg.channel_count <= pwdata[1:0];
                default:   ;
            endcase
        end
    end

    // read back
    always_comb
    begin
        unique case (paddr[3:2])
            REG_MODE:  prdata = {29'b0, cfg_reg.mode};
            REG_WIDTH: prdata = {21'b0, cfg_reg.line_width};
            REG_CHANS: prdata = {30'b0, cfg_reg.channel_count};
            default:   prdata = '0;
        endcase
    end

    // front: counters, line buffers, window assembly
    w3f_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .push   (push),
        .pixel  (pixel),
        .full   (full),
        .q_stat (q_stat),
        .q_wr   (q_wr),
        .q_data (q_wr_data)
    );

    // short queue of windows
    w3f_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_wr),
        .wr_data (q_wr_data),
        .rd      (q_rd),
        .rd_data (q_rd_data),
        .stat    (q_stat)
    );

    // back: filter arithmetic and result beat
    w3f_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .q_stat (q_stat),
        .q_data (q_rd_data),
        .q_rd   (q_rd),
        .pop    (pop),
        .empty  (empty),
        .result (result)
    );

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_wr && q_stat.full))
        else $error("window queue written while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_rd && q_stat.empty))
        else $error("window queue read while empty");
    a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full) |=> full)
        else $error("front not busy after an input beat");
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("waiting result lost or changed");
`endif
endmodule
`default_nettype wire

### tb/window_3x3_image_filter_unit_tb.sv
// self-checking testbench for the 3x3 window image filter unit
`timescale 1ns / 1ps
module window_3x3_image_filter_unit_tb;
    import w3f_pkg::*;

    localparam int LIMIT_CYCLES = 2000000;
    localparam int SETTLE_CYCLES = 60;
    localparam int FILL_WIDTH = 64;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        push = 1'b0;
    pixel_t      pixel = '0;
    logic        full;
    logic        empty;
    logic        pop = 1'b0;
    result_t     result;

    window_3x3_image_filter_unit u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .push    (push),
        .pixel   (pixel),
        .full    (full),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

    always #10 clk = ~clk;

    // pixels waiting to be pushed and filtered pixels still owed by the block
    pixel_t  pixel_q[$];
    result_t filtered_q[$];

    // own copy of the configuration and of the window state
    int          cfg_mode = 0;
    int          cfg_width = 640;
    int          cfg_chans = 1;
    logic [23:0] upper_mem[MAX_LINE_WIDTH];
    logic [23:0] middle_mem[MAX_LINE_WIDTH];
    logic [23:0] win_cols[6];
    int          col_cnt = 0;
    int          row_cnt = 0;

    int  errors = 0;
    int  cycles = 0;
    bit  hold_push = 1'b1;
    bit  no_idle = 1'b0;
    bit  push_took = 1'b0;
    bit  pop_took = 1'b0;
    int  push_gap = 0;
    int  pop_gap = 0;
    int  rand_items = 0;

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic int isqrt_floor(int v);
        int r;
        r = 0;
        while ((r + 1) * (r + 1) <= v)
            r++;
        return r;
    endfunction

    // w indexed row*3+col, row 0 the top one
    function automatic logic [11:0] filter_window(int mode, int w[9]);
        int s;
        int gx;
        int gy;
        int t;
        int v[9];
        s = 0;
        case (mode)
            MODE_AVERAGE:
            begin
                foreach (w[i])
                    s += w[i];
                s = s / 9;
            end
            MODE_GAUSSIAN:
            begin
                s = (w[0] + 2 * w[1] + w[2] + 2 * w[3] + 4 * w[4] + 2 * w[5]
                    + w[6] + 2 * w[7] + w[8]) / 16;
            end
            MODE_LAPLACIAN:
                s = w[1] + w[3] + w[5] + w[7] - 4 * w[4];
            MODE_SHARPEN:
            begin
                foreach (w[i])
                    s -= w[i];
                s += 10 * w[4];
                if (s > 255)
                    s = 255;
                if (s < 0)
                    s = 0;
            end
            MODE_SOBEL:
            begin
                gx = (w[0] - w[2]) + 2 * (w[3] - w[5]) + (w[6] - w[8]);
                gy = (w[0] + 2 * w[1] + w[2]) - (w[6] + 2 * w[7] + w[8]);
                s = isqrt_floor(gx * gx + gy * gy);
            end
            MODE_MEDIAN:
            begin
                v = w;
                for (int a = 0; a < 9; a++)
                    for (int b = 0; b < 8 - a; b++)
                        if (v[b] > v[b + 1])
                        begin
                            t = v[b];
                            v[b] = v[b + 1];
                            v[b + 1] = t;
                        end
                s = v[4];
            end
            default:
                s = 0;
        endcase
        return s[11:0];
    endfunction

    // advance the window state by one pixel and queue the filtered pixel it yields
    task automatic predict_pixel(pixel_t p);
        int          lw;
        int          ch;
        int          col;
        logic [23:0] cw[9];
        int          w[9];
        logic [11:0] f[3];
        result_t     r;
        lw = cfg_width < 3 ? 3 : (cfg_width > MAX_LINE_WIDTH ? MAX_LINE_WIDTH : cfg_width);
        ch = cfg_chans == 0 ? 1 : cfg_chans;
        if (p.frame_start)
        begin
            col_cnt = 0;
            row_cnt = 0;
        end
        // width lowered under a part-done line: start a fresh one
        if (col_cnt >= lw)
        begin
            col_cnt = 0;
            if (row_cnt < 2)
                row_cnt++;
        end
        col = col_cnt;
        // cw indexed column*3+row
        for (int i = 0; i < 6; i++)
            cw[i] = win_cols[i];
        cw[6] = upper_mem[col];
        cw[7] = middle_mem[col];
        cw[8] = {p.pixel_c2, p.pixel_c1, p.pixel_c0};
        upper_mem[col] = cw[7];
        middle_mem[col] = cw[8];
        if (row_cnt >= 2 && col >= 2)
        begin
            for (int k = 0; k < 3; k++)
            begin
                f[k] = '0;
                if (k < ch)
                begin
                    for (int rr = 0; rr < 3; rr++)
                        for (int cc = 0; cc < 3; cc++)
                            w[rr * 3 + cc] = (cw[cc * 3 + rr] >> (8 * k)) & 8'hff;
                    f[k] = filter_window(cfg_mode, w);
                end
            end
            r.filtered_c0 = f[0];
            r.filtered_c1 = f[1];
            r.filtered_c2 = f[2];
            r.row_end = (col + 1 >= lw);
            filtered_q = {filtered_q, r};
        end
        for (int i = 0; i < 3; i++)
        begin
            win_cols[i] = win_cols[3 + i];
            win_cols[3 + i] = cw[6 + i];
        end
        if (col + 1 >= lw)
        begin
            col_cnt = 0;
            if (row_cnt < 2)
                row_cnt++;
        end
        else
            col_cnt = col + 1;
    endtask

    // input monitor and result checker, sampled on the rising edge
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("[window_3x3_image_filter_unit] ERROR");
            $finish;
        end
        else
        begin
            if (rst_n && push && !full)
            begin
                predict_pixel(pixel);
                push_took = 1'b1;
            end
            if (rst_n && pop && !empty)
            begin
                pop_took = 1'b1;
                if (filtered_q.size() == 0)
                begin
                    $display("%0t: unexpected result beat %h", $time, result);
                    errors++;
                end
                else
                begin
                    if (result.filtered_c0 !== filtered_q[0].filtered_c0)
                    begin
                        $display("%0t: filtered_c0 expected %0d got %0d", $time,
                            filtered_q[0].filtered_c0, result.filtered_c0);
                        errors++;
                    end
                    if (result.filtered_c1 !== filtered_q[0].filtered_c1)
                    begin
                        $display("%0t: filtered_c1 expected %0d got %0d", $time,
                            filtered_q[0].filtered_c1, result.filtered_c1);
                        errors++;
                    end
                    if (result.filtered_c2 !== filtered_q[0].filtered_c2)
                    begin
                        $display("%0t: filtered_c2 expected %0d got %0d", $time,
                            filtered_q[0].filtered_c2, result.filtered_c2);
                        errors++;
                    end
                    if (result.row_end !== filtered_q[0].row_end)
                    begin
                        $display("%0t: row_end expected %0b got %0b", $time,
                            filtered_q[0].row_end, result.row_end);
                        errors++;
                    end
                    void'(filtered_q.pop_front());
                end
            end
        end
    end

    // pixel driver: holds a beat until it is taken, then maybe idles
    always @(negedge clk)
    begin
        if (push_took)
        begin
            void'(pixel_q.pop_front());
            push_took = 1'b0;
            push_gap = pick_gap();
        end
        if (push_gap > 0)
        begin
            push_gap--;
            push <= 1'b0;
        end
        else if (!hold_push && pixel_q.size() > 0)
        begin
            push <= 1'b1;
            pixel <= pixel_q[0];
        end
        else
            push <= 1'b0;
    end

    // result side: pop with random stalls
    always @(negedge clk)
    begin
        if (pop_took)
        begin
            pop_took = 1'b0;
            pop_gap = pick_gap();
        end
        if (pop_gap > 0)
        begin
            pop_gap--;
            pop <= 1'b0;
        end
        else
            pop <= 1'b1;
    end

    // register write: setup beat then access beat
    task automatic write_reg(logic [1:0] idx, int value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_MODE:  cfg_mode = value & 7;
            REG_WIDTH: cfg_width = value & 11'h7ff;
            default:   cfg_chans = value & 3;
        endcase
    endtask

    // let everything queued drain, then allow the back end to go quiet
    task automatic drain_all();
        hold_push = 1'b0;
        while (pixel_q.size() != 0 || filtered_q.size() != 0)
            @(posedge clk);
        hold_push = 1'b1;
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic configure(int mode, int width, int chans);
        write_reg(REG_MODE, mode);
        write_reg(REG_WIDTH, width);
        write_reg(REG_CHANS, chans);
    endtask

    function automatic logic [7:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hff;
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    task automatic queue_pixel(bit fs, logic [7:0] a, logic [7:0] b, logic [7:0] c);
        pixel_t p;
        p.frame_start = fs;
        p.pixel_c0 = a;
        p.pixel_c1 = b;
        p.pixel_c2 = c;
        pixel_q = {pixel_q, p};
    endtask

    initial
    begin
        int width;
        int lw;
        int rows;
        bit fs_first;
        foreach (win_cols[i])
            win_cols[i] = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // fill both line buffers across the widest line used below so no stale entry is read
        configure(MODE_AVERAGE, FILL_WIDTH, 3);
        for (int i = 0; i < 2 * FILL_WIDTH; i++)
            queue_pixel(i == 0, $urandom_range(0, 255), $urandom_range(0, 255),
                $urandom_range(0, 255));
        drain_all();

        // checkerboard of extremes under sobel on all components
        configure(MODE_SOBEL, 3, 3);
        for (int i = 0; i < 9; i++)
            if (i % 2 == 0)
                queue_pixel(i == 0, 8'hff, 8'h00, 8'hff);
            else
                queue_pixel(1'b0, 8'h00, 8'hff, 8'h00);
        drain_all();

        // width under three and zero channels, bright centre then dark centre
        configure(MODE_SHARPEN, 0, 0);
        for (int i = 0; i < 12; i++)
            if (i == 4)
                queue_pixel(1'b0, 8'hff, 8'hff, 8'hff);
            else if (i == 7)
                queue_pixel(1'b0, 8'h00, 8'h00, 8'h00);
            else
                queue_pixel(i == 0, i == 7 ? 8'h00 : 8'hff, 8'hff, 8'h80);
        drain_all();

        // random frames, each under its own setting
        while (rand_items < 1200)
        begin
            no_idle = ($urandom_range(0, 5) == 0);
            case ($urandom_range(0, 29))
                0, 1:    width = FILL_WIDTH;
                2, 3, 4: width = $urandom_range(0, 2);
                5, 6:    width = $urandom_range(20, FILL_WIDTH);
                default: width = $urandom_range(3, 12);
            endcase
            configure($urandom_range(0, 7), width, $urandom_range(0, 3));
            lw = width < 3 ? 3 : (width > MAX_LINE_WIDTH ? MAX_LINE_WIDTH : width);
            rows = lw > 64 ? 3 : $urandom_range(3, 6);
            fs_first = ($urandom_range(0, 9) != 0);
            for (int i = 0; i < rows * lw; i++)
                queue_pixel((i == 0 && fs_first) || $urandom_range(0, 199) == 0,
                    pick_sample(), pick_sample(), pick_sample());
            // a part line left behind, so a later narrower width cuts it short
            if (lw > 3 && $urandom_range(0, 2) == 0)
                for (int i = $urandom_range(1, lw - 1); i > 0; i--)
                    queue_pixel(1'b0, pick_sample(), pick_sample(), pick_sample());
            rand_items += pixel_q.size();
            drain_all();
        end

        if (errors == 0)
            $display("[window_3x3_image_filter_unit] OK");
        else
            $display("[window_3x3_image_filter_unit] ERROR");
        $finish;
    end

endmodule
